### hw/rtl/drs_pkg.sv
// shared types, widths and constants for the depth row steering block
`timescale 1ns / 1ps

package drs_pkg;

    // field widths
    localparam int DEPTH_W   = 16;
    localparam int ROW_W     = 12;
    localparam int DIST_W    = 16;
    localparam int RPM_W     = 8;
    localparam int SPEED_W   = 10;
    localparam int MAG_W     = SPEED_W - 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // divider sizing: numerator holds 2 * max_rpm * depth difference
    localparam int NUM_W  = RPM_W + 1 + DEPTH_W;
    localparam int DEN_W  = 16;
    localparam int QCNT_W = $clog2(NUM_W);

    // default row capacity
    localparam int MAX_WIDTH_DEF = 2048;

    // register reset values
    localparam logic             ENABLE_RST    = 1'b1;
    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(640);
    localparam logic [DIST_W-1:0] MAX_DIST_RST = DIST_W'(300);
    localparam logic [RPM_W-1:0] MAX_RPM_RST   = RPM_W'(40);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_ROW_WIDTH = 2'd1,
        CFG_MAX_DIST  = 2'd2,
        CFG_MAX_RPM   = 2'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_OUT  = 2'd3
    } t_drs_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load_div;
        logic div_step;
        logic load_out;
    } t_drs_cmd;

    // datapath to controller
    typedef struct packed {
        logic row_end;
        logic div_done;
        logic out_free;
    } t_drs_sts;

endpackage

### hw/rtl/drs_ctrl.sv
// controller state machine: sample intake, multiply, divide, result hand-off
`timescale 1ns / 1ps

module drs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  drs_pkg::t_drs_sts i_sts,
    output drs_pkg::t_drs_cmd o_cmd
);

    drs_pkg::t_drs_state r_state;
    drs_pkg::t_drs_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            drs_pkg::ST_IDLE: begin
                if (i_valid && i_sts.row_end) begin
                    n_state = drs_pkg::ST_MUL;
                end
            end
            drs_pkg::ST_MUL: begin
                n_state = drs_pkg::ST_DIV;
            end
            drs_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = drs_pkg::ST_OUT;
                end
            end
            drs_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = drs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = drs_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            drs_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            drs_pkg::ST_MUL: begin
                o_cmd.load_div = 1'b1;
            end
            drs_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            drs_pkg::ST_OUT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/drs_datapath.sv
// datapath: nearest-sample tracking, shared multiplier, serial divider, output register
`timescale 1ns / 1ps

module drs_datapath #(
    parameter int MAX_WIDTH = drs_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  drs_pkg::t_drs_cmd                   i_cmd,
    output drs_pkg::t_drs_sts                   o_sts,
    input  logic                                i_valid,
    input  logic [drs_pkg::DEPTH_W-1:0]         i_depth,
    input  logic                                i_last,
    input  logic                                i_enable,
    input  logic [drs_pkg::ROW_W-1:0]           i_row_width,
    input  logic [drs_pkg::DIST_W-1:0]          i_max_dist,
    input  logic [drs_pkg::RPM_W-1:0]           i_max_rpm,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic                                o_halted,
    output logic signed [drs_pkg::SPEED_W-1:0]  o_left_speed,
    output logic signed [drs_pkg::SPEED_W-1:0]  o_right_speed
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = WW - 1;
    localparam int DW = drs_pkg::DEPTH_W;
    localparam int NW = drs_pkg::NUM_W;
    localparam int EW = drs_pkg::DEN_W;
    localparam int MW = drs_pkg::MAG_W;
    localparam int SW = drs_pkg::SPEED_W;

    // tracking state
    logic [CW-1:0] r_column, n_column;
    logic [DW-1:0] r_near_l, n_near_l;
    logic [DW-1:0] r_near_r, n_near_r;
    logic [CW-1:0] r_off_l, n_off_l;
    logic [CW-1:0] r_off_r, n_off_r;
    logic          r_found_l, n_found_l;
    logic          r_found_r, n_found_r;

    // divider state
    logic [NW-1:0]               r_quo, n_quo;
    logic [EW-1:0]               r_rem, n_rem;
    logic [EW-1:0]               r_den, n_den;
    logic [drs_pkg::QCNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_den_zero, n_den_zero;
    logic                        r_halt, n_halt;
    logic                        r_neg_l, n_neg_l;
    logic                        r_neg_r, n_neg_r;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_halted, n_out_halted;
    logic signed [SW-1:0] r_out_left, n_out_left;
    logic signed [SW-1:0] r_out_right, n_out_right;

    // row geometry
    logic [WW-1:0] width;
    logic [HW-1:0] half;
    logic [WW-1:0] col_ext;
    logic [WW-1:0] half_ext;
    logic          take;
    logic          sample_ok;

    // multiplier operands
    logic                   near_l_less;
    logic [DW-1:0]          diff;
    logic [drs_pkg::RPM_W:0] op_a;
    logic [DW-1:0]          op_b;
    logic [NW-1:0]          prod;
    logic [EW-1:0]          den_sel;

    // divider step
    logic [EW:0]   rem_sh;
    logic          rem_ge;
    logic [MW-1:0] mag;
    logic [SW-1:0] spd_pos;

    assign width    = (i_row_width > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(i_row_width);
    assign half     = width[WW-1:1];
    assign half_ext = WW'(half);
    assign col_ext  = WW'(r_column);
    assign take     = i_valid && i_cmd.in_ready && i_enable;
    assign sample_ok = (col_ext < width) && (i_depth != '0) && (i_depth < i_max_dist);

    // nearest sample tracking per half, cleared when a row result is started
    always_comb begin
        n_column  = r_column;
        n_near_l  = r_near_l;
        n_near_r  = r_near_r;
        n_off_l   = r_off_l;
        n_off_r   = r_off_r;
        n_found_l = r_found_l;
        n_found_r = r_found_r;
        if (i_cmd.load_div) begin
            n_column  = '0;
            n_near_l  = '0;
            n_near_r  = '0;
            n_off_l   = '0;
            n_off_r   = '0;
            n_found_l = 1'b0;
            n_found_r = 1'b0;
        end else if (take) begin
            if (sample_ok) begin
                if (col_ext < half_ext) begin
                    if (!r_found_l || i_depth < r_near_l) begin
                        n_near_l  = i_depth;
                        n_off_l   = CW'(half_ext - col_ext - WW'(1));
                        n_found_l = 1'b1;
                    end
                end else begin
                    if (!r_found_r || i_depth < r_near_r) begin
                        n_near_r  = i_depth;
                        n_off_r   = CW'(col_ext - half_ext);
                        n_found_r = 1'b1;
                    end
                end
            end
            if (r_column < CW'(MAX_WIDTH - 1)) begin
                n_column = r_column + CW'(1);
            end
        end
    end

    // operand selection for the single multiplier
    always_comb begin
        near_l_less = r_near_l < r_near_r;
        diff        = near_l_less ? (r_near_r - r_near_l) : (r_near_l - r_near_r);
        op_a        = {1'b0, i_max_rpm};
        op_b        = '0;
        den_sel     = EW'(half);
        n_halt      = 1'b0;
        n_neg_l     = 1'b0;
        n_neg_r     = 1'b0;
        if (!r_found_l && !r_found_r) begin
            n_halt = 1'b1;
        end else if (!r_found_l) begin
            op_b    = DW'(r_off_r);
            n_neg_r = 1'b1;
        end else if (!r_found_r) begin
            op_b    = DW'(r_off_l);
            n_neg_l = 1'b1;
        end else begin
            op_a    = {i_max_rpm, 1'b0};
            op_b    = diff;
            den_sel = EW'(i_max_dist);
            n_neg_l = !near_l_less;
            n_neg_r = !near_l_less;
        end
    end

    assign prod = op_a * op_b;

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_den      = r_den;
        n_cnt      = r_cnt;
        n_den_zero = r_den_zero;
        if (i_cmd.load_div) begin
            n_quo      = prod;
            n_rem      = '0;
            n_den      = den_sel;
            n_cnt      = '0;
            n_den_zero = (den_sel == '0);
        end else if (i_cmd.div_step) begin
            n_quo = {r_quo[NW-2:0], rem_ge};
            n_rem = rem_ge ? EW'(rem_sh - {1'b0, r_den}) : rem_sh[EW-1:0];
            n_cnt = r_cnt + drs_pkg::QCNT_W'(1);
        end
    end

    // signed wheel speeds from the quotient
    assign mag     = (r_den_zero || r_halt) ? '0 : r_quo[MW-1:0];
    assign spd_pos = {1'b0, mag};

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_halted = r_out_halted;
        n_out_left   = r_out_left;
        n_out_right  = r_out_right;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_out_valid  = 1'b1;
            n_out_halted = r_halt;
            n_out_left   = r_neg_l ? -$signed(spd_pos) : $signed(spd_pos);
            n_out_right  = r_neg_r ? -$signed(spd_pos) : $signed(spd_pos);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_found_l   <= 1'b0;
            r_found_r   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_column    <= n_column;
            r_found_l   <= n_found_l;
            r_found_r   <= n_found_r;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers, cleared with the tracking where the row needs it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_l <= '0;
            r_near_r <= '0;
            r_off_l  <= '0;
            r_off_r  <= '0;
        end else begin
            r_near_l <= n_near_l;
            r_near_r <= n_near_r;
            r_off_l  <= n_off_l;
            r_off_r  <= n_off_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_den_zero   <= n_den_zero;
        r_out_halted <= n_out_halted;
        r_out_left   <= n_out_left;
        r_out_right  <= n_out_right;
        if (i_cmd.load_div) begin
            r_halt  <= n_halt;
            r_neg_l <= n_neg_l;
            r_neg_r <= n_neg_r;
        end
    end

    // status back to the controller
    assign o_sts.row_end  = i_enable && i_last;
    assign o_sts.div_done = i_cmd.div_step && (r_cnt == drs_pkg::QCNT_W'(NW - 1));
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_halted      = r_out_halted;
    assign o_left_speed  = r_out_left;
    assign o_right_speed = r_out_right;

endmodule

### hw/rtl/depth_row_steering.sv
// top level: configuration registers, controller and datapath of the row steering block
`timescale 1ns / 1ps

// Steering from one row of depth samples.
// Input channel (i_valid / o_ready) carries one depth sample per item, in mm,
// column 0 first, with i_last on the final sample of the row. Result channel
// (o_valid / i_ready) carries one wheel command per row: o_halted and the
// signed left and right speeds in rpm.
// While the controller is idle, samples that are not the end of a row are
// taken one per cycle. The row-end item starts a product step and a restoring
// divide, and its result is then loaded into the output register; o_ready
// stays low until then, so no sample of the next row is taken meanwhile.
// The result sits in an output register: while the receiver stalls, new
// samples of the next row are still taken; only a second row end waits for
// the register to drain before its result is loaded.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and are
// meant for idle periods. With enable at 0, samples are taken and dropped.
// Reset (synchronous, active low) restores register defaults: enable 1,
// row_width 640, max_dist 300, max_rpm 40, and clears the row tracking.
// No clearing pass is needed after reset.
module depth_row_steering #(
    parameter int MAX_WIDTH = drs_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [drs_pkg::DEPTH_W-1:0]         i_depth,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_halted,
    output logic signed [drs_pkg::SPEED_W-1:0]  o_left_speed,
    output logic signed [drs_pkg::SPEED_W-1:0]  o_right_speed,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [drs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [drs_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    logic                         r_enable;
    logic [drs_pkg::ROW_W-1:0]    r_row_width;
    logic [drs_pkg::DIST_W-1:0]   r_max_dist;
    logic [drs_pkg::RPM_W-1:0]    r_max_rpm;

    drs_pkg::t_drs_cmd cmd;
    drs_pkg::t_drs_sts sts;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = cmd.in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= drs_pkg::ENABLE_RST;
            r_row_width <= drs_pkg::ROW_WIDTH_RST;
            r_max_dist  <= drs_pkg::MAX_DIST_RST;
            r_max_rpm   <= drs_pkg::MAX_RPM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (drs_pkg::t_cfg_idx'(i_cfg_index))
                drs_pkg::CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                drs_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data[drs_pkg::ROW_W-1:0];
                drs_pkg::CFG_MAX_DIST:  r_max_dist  <= i_cfg_data[drs_pkg::DIST_W-1:0];
                drs_pkg::CFG_MAX_RPM:   r_max_rpm   <= i_cfg_data[drs_pkg::RPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller
    drs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    drs_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_valid       (i_valid),
        .i_depth       (i_depth),
        .i_last        (i_last),
        .i_enable      (r_enable),
        .i_row_width   (r_row_width),
        .i_max_dist    (r_max_dist),
        .i_max_rpm     (r_max_rpm),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_halted      (o_halted),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed)
    );

`ifndef ASSERT_OFF
    // a halted command carries zero speeds
    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> (o_left_speed == '0) && (o_right_speed == '0))
        else $error("halted result with nonzero speed");

    // a moving command turns both wheels at the same magnitude
    a_same_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_halted |->
            (o_left_speed == o_right_speed) || (o_left_speed == -o_right_speed))
        else $error("wheel speed magnitudes differ");

    // a row end taken while enabled blocks intake for the divide
    a_row_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && r_enable && i_last |=> !o_ready)
        else $error("intake not paused after row end");

    // the left speed stays within twice the largest max_rpm
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_speed >= -10'sd510) && (o_left_speed <= 10'sd510))
        else $error("speed out of range");
`endif

endmodule

### verif/depth_row_steering_tb.sv
// testbench for depth_row_steering: directed and random rows checked against a predictor
`timescale 1ns / 1ps

module depth_row_steering_tb;

    localparam int DEPTH_W   = drs_pkg::DEPTH_W;
    localparam int ROW_W     = drs_pkg::ROW_W;
    localparam int DIST_W    = drs_pkg::DIST_W;
    localparam int RPM_W     = drs_pkg::RPM_W;
    localparam int SPEED_W   = drs_pkg::SPEED_W;
    localparam int CFG_IDX_W = drs_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = drs_pkg::CFG_DAT_W;

    localparam int ROW_CAP       = drs_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASE_ITEMS   = 90;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 1000;
    localparam int MAX_PRINTED   = 40;

    // directed rows at row_width 4, depth limit 300, max_rpm 255: {last, depth}
    localparam logic [DEPTH_W:0] DIRECTED_ROWS [22] = '{
        // nothing valid: depth at the limit and at the top of the range
        {1'b0, 16'd300}, {1'b0, 16'd65535}, {1'b1, 16'd0},
        // left only, just below the limit
        {1'b0, 16'd299}, {1'b1, 16'd0},
        // right only, a tie keeps the first column
        {1'b0, 16'd0}, {1'b0, 16'd0}, {1'b0, 16'd7}, {1'b1, 16'd7},
        // both halves, left nearer: forward at nearly full speed
        {1'b0, 16'd1}, {1'b0, 16'd0}, {1'b0, 16'd299}, {1'b1, 16'd0},
        // both halves, right nearer: backward
        {1'b0, 16'd250}, {1'b0, 16'd250}, {1'b0, 16'd1}, {1'b1, 16'd0},
        // overlong row: the sample past row_width is not tracked
        {1'b0, 16'd0}, {1'b0, 16'd0}, {1'b0, 16'd0}, {1'b0, 16'd0}, {1'b1, 16'd5}
    };

    // wheel commands owed for the row ends taken so far
    class t_steer_predictor;
        typedef struct packed {
            logic                      halted;
            logic signed [SPEED_W-1:0] left_rpm;
            logic signed [SPEED_W-1:0] right_rpm;
        } t_wheel_cmd;

        logic              en;
        logic [ROW_W-1:0]  row_width;
        logic [DIST_W-1:0] depth_limit;
        logic [RPM_W-1:0]  max_rpm;
        int unsigned       column;
        int unsigned       near_l;
        int unsigned       near_r;
        int unsigned       off_l;
        int unsigned       off_r;
        bit                found_l;
        bit                found_r;
        int                checked;
        t_wheel_cmd        cmds_due[$];

        function new();
            en          = drs_pkg::ENABLE_RST;
            row_width   = drs_pkg::ROW_WIDTH_RST;
            depth_limit = drs_pkg::MAX_DIST_RST;
            max_rpm     = drs_pkg::MAX_RPM_RST;
            checked     = 0;
            clear_row();
        endfunction

        function void clear_row();
            column  = 0;
            near_l  = 0;
            near_r  = 0;
            off_l   = 0;
            off_r   = 0;
            found_l = 0;
            found_r = 0;
        endfunction

        function void set_reg(drs_pkg::t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                drs_pkg::CFG_ENABLE:    en = data[0];
                drs_pkg::CFG_ROW_WIDTH: row_width = data[ROW_W-1:0];
                drs_pkg::CFG_MAX_DIST:  depth_limit = data[DIST_W-1:0];
                drs_pkg::CFG_MAX_RPM:   max_rpm = data[RPM_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic [DEPTH_W-1:0] depth, logic last);
            int unsigned       width;
            int unsigned       half;
            int unsigned       r;
            int unsigned       diff;
            bit                neg_l;
            bit                neg_r;
            logic [SPEED_W-1:0] mag;
            t_wheel_cmd        cmd;
            if (!en) return;
            width = (row_width > ROW_CAP) ? ROW_CAP : row_width;
            half  = width >> 1;
            // nearest valid sample per half, strict compare keeps the first
            if (column < width && depth != 0 && depth < depth_limit) begin
                if (column < half) begin
                    if (!found_l || depth < near_l) begin
                        near_l  = depth;
                        off_l   = half - column - 1;
                        found_l = 1;
                    end
                end else if (!found_r || depth < near_r) begin
                    near_r  = depth;
                    off_r   = column - half;
                    found_r = 1;
                end
            end
            if (column < ROW_CAP - 1) column++;
            if (!last) return;
            // wheel command at the row end
            r     = 0;
            neg_l = 0;
            neg_r = 0;
            if (found_l && found_r) begin
                neg_l = (near_l >= near_r);
                neg_r = neg_l;
                diff  = neg_l ? near_l - near_r : near_r - near_l;
                r     = (depth_limit != 0) ? (2 * max_rpm * diff) / depth_limit : 0;
            end else if (found_r) begin
                neg_r = 1;
                r     = (half != 0) ? (max_rpm * off_r) / half : 0;
            end else if (found_l) begin
                neg_l = 1;
                r     = (half != 0) ? (max_rpm * off_l) / half : 0;
            end
            mag           = r[SPEED_W-1:0];
            cmd.halted    = !found_l && !found_r;
            cmd.left_rpm  = neg_l ? -mag : mag;
            cmd.right_rpm = neg_r ? -mag : mag;
            cmds_due.push_back(cmd);
            clear_row();
        endfunction

        function string check_command(logic halted, logic signed [SPEED_W-1:0] left_rpm,
                                      logic signed [SPEED_W-1:0] right_rpm);
            t_wheel_cmd want;
            string      why;
            if (cmds_due.size() == 0)
                return $sformatf("wheel command with no row end pending %s",
                                 $sformatf("(halted %0b left %0d right %0d)",
                                           halted, left_rpm, right_rpm));
            want = cmds_due.pop_front();
            checked++;
            why  = "";
            if (halted !== want.halted)
                why = {why, $sformatf(" halted %0b expected %0b", halted, want.halted)};
            if (left_rpm !== want.left_rpm)
                why = {why, $sformatf(" left %0d expected %0d", left_rpm, want.left_rpm)};
            if (right_rpm !== want.right_rpm)
                why = {why, $sformatf(" right %0d expected %0d", right_rpm, want.right_rpm)};
            if (why != "") why = $sformatf("command %0d:%s", checked, why);
            return why;
        endfunction

        function int pending();
            return cmds_due.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_ready;
    logic [DEPTH_W-1:0]        i_depth     = '0;
    logic                      i_last      = 1'b0;
    logic                      o_valid;
    logic                      i_ready     = 1'b0;
    logic                      o_halted;
    logic signed [SPEED_W-1:0] o_left_speed;
    logic signed [SPEED_W-1:0] o_right_speed;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = drs_pkg::CFG_ENABLE;
    logic [CFG_DAT_W-1:0]      i_cfg_data  = '0;

    t_steer_predictor steer;
    bit               calm = 1'b0;
    bit               gen_en;
    int               gen_width;
    int               gen_dist;
    int               n_errors   = 0;
    int               n_samples  = 0;
    int               n_commands = 0;
    int               n_halts    = 0;
    int               n_writes   = 0;
    int               quiet      = 0;
    string            mismatch_note;

    depth_row_steering dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_depth       (i_depth),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_halted      (o_halted),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTED) $display("%0t ns: %s", $time, what);
    endtask

    // idle length: mostly short, now and then long
    function automatic int idle_span();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 50);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_sample(input logic [DEPTH_W-1:0] depth, input logic last);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? idle_span() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_depth <= depth;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (steer.pending() != 0) @(posedge i_clk);
    endtask

    // let the end-of-row divide finish before touching registers
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input drs_pkg::t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry junk
    task automatic program_regs(input bit en, input int width, input int dist_mm,
                                input int rpm);
        logic [CFG_DAT_W-1:0] junk;
        logic [ROW_W-1:0]     w;
        logic [RPM_W-1:0]     m;
        junk = CFG_DAT_W'($urandom);
        w    = ROW_W'(width);
        m    = RPM_W'(rpm);
        write_reg(drs_pkg::CFG_ENABLE, {junk[CFG_DAT_W-1:1], en});
        write_reg(drs_pkg::CFG_ROW_WIDTH, {junk[CFG_DAT_W-1:ROW_W], w});
        write_reg(drs_pkg::CFG_MAX_DIST, dist_mm[CFG_DAT_W-1:0]);
        write_reg(drs_pkg::CFG_MAX_RPM, {junk[CFG_DAT_W-1:RPM_W], m});
        gen_en    = en;
        gen_width = width;
        gen_dist  = dist_mm;
    endtask

    // depth inside the valid window when asked, with some noise either way
    function automatic logic [DEPTH_W-1:0] pick_depth(input bit want_valid);
        int r;
        int hi;
        r = $urandom_range(0, 9);
        if (want_valid && gen_dist >= 2 && r < 8) begin
            hi = gen_dist - 1;
            case (r)
                0: return DEPTH_W'(1);
                1: return DEPTH_W'(hi);
                2, 3: return DEPTH_W'($urandom_range(1, (hi < 8) ? hi : 8));
                default: return DEPTH_W'($urandom_range(1, hi));
            endcase
        end
        case (r % 5)
            0: return '0;
            1: return DEPTH_W'(gen_dist);
            2: return {DEPTH_W{1'b1}};
            3: return DEPTH_W'($urandom_range(gen_dist, 65535));
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    // one row: a random length and a choice of which halves see valid depths
    task automatic send_random_row(output int sent);
        int eff;
        int half;
        int len;
        int mode;
        bit want;
        eff  = (gen_width > ROW_CAP) ? ROW_CAP : gen_width;
        half = eff >> 1;
        if (eff == 0) begin
            len = $urandom_range(1, 4);
        end else if (eff > 64) begin
            len = $urandom_range(1, 40);
        end else begin
            case ($urandom_range(0, 7))
                5: len = $urandom_range(1, eff);
                6: len = eff + $urandom_range(1, 4);
                7: len = $urandom_range(1, 3);
                default: len = eff;
            endcase
        end
        mode = $urandom_range(0, 5);
        for (int c = 0; c < len; c++) begin
            want = (c < half) ? (mode == 1 || mode >= 3) : (mode == 2 || mode >= 3);
            send_sample(pick_depth(want), c == len - 1);
        end
        sent = len;
    endtask

    // result receiver with random stalls
    initial begin
        int span;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                span    = idle_span();
                i_ready <= 1'b0;
                repeat (span) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // checker: results first, then accepted items and register writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                mismatch_note = steer.check_command(o_halted, o_left_speed, o_right_speed);
                if (mismatch_note != "") report_mismatch(mismatch_note);
                n_commands++;
                if (o_halted) n_halts++;
            end
            if (i_valid && o_ready) begin
                steer.take_sample(i_depth, i_last);
                n_samples++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                steer.set_reg(drs_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
                n_writes++;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("no item moved for %0d cycles", QUIET_LIMIT);
            $display("depth_row_steering verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        int phase;
        int random_sent;
        int phase_sent;
        int n;
        steer = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one left sample far from the centre
        send_sample(16'd100, 1'b0);
        send_sample(16'd0, 1'b1);
        settle();

        // directed rows, draining after each row end
        program_regs(1'b1, 4, 300, 255);
        for (int i = 0; i < 22; i++) begin
            send_sample(DIRECTED_ROWS[i][DEPTH_W-1:0], DIRECTED_ROWS[i][DEPTH_W]);
            if (DIRECTED_ROWS[i][DEPTH_W]) hold_until_drained();
        end
        settle();

        // stopped: a row end gives nothing
        program_regs(1'b0, 4, 300, 255);
        send_sample(16'd5, 1'b1);
        settle();

        // random phases, extremes of the registers first
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                // narrowest row with both halves
                0: program_regs(1'b1, 2, 65535, 255);
                // zero half: no left side, zero turn rate
                1: program_regs(1'b1, 1, 300, 100);
                // wide row_width, nothing can be below the depth limit
                2: program_regs(1'b1, 4095, 1, 0);
                // zero width and zero depth limit
                3: program_regs(1'b1, 0, 0, 255);
                // stopped
                4: program_regs(1'b0, $urandom_range(2, 40), 300, 40);
                5: program_regs(1'b1, 2048, 65535, 255);
                6: program_regs(1'b1, 2047, $urandom_range(1, 65535), $urandom_range(0, 255));
                default: program_regs(1'b1, $urandom_range(2, 48),
                                      ($urandom_range(0, 1) == 1) ? $urandom_range(2, 600)
                                                                  : $urandom_range(1, 65535),
                                      $urandom_range(0, 255));
            endcase
            calm       = ($urandom_range(0, 3) == 0);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                send_random_row(n);
                phase_sent += n;
                if ($urandom_range(0, 14) == 0) hold_until_drained();
            end
            random_sent += phase_sent;
            settle();
            phase++;
        end

        $display("covered %0d samples over %0d register settings with %0d register writes",
                 n_samples, phase + 3, n_writes);
        $display("checked %0d wheel commands, %0d of them halts", n_commands, n_halts);
        if (n_errors == 0)
            $display("depth_row_steering verification clean");
        else
            $display("depth_row_steering verification failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/drs_pkg.sv
hw/rtl/drs_ctrl.sv
hw/rtl/drs_datapath.sv
hw/rtl/depth_row_steering.sv
verif/depth_row_steering_tb.sv
